@@ sv/ubx_pkg.sv @@
// ----------------------------------------------------------------------------
// UBX frame parser package
// Protocol constants, message and status codes, result type and the
// field offset tables of the navigation messages.
// ----------------------------------------------------------------------------
package ubx_pkg;

    localparam int FRAME_BYTES    = 64;
    localparam int HEADER_BYTES   = 6;
    localparam int FRAME_OVERHEAD = 8;

    localparam logic [7:0] SYNC_FIRST     = 8'hB5;
    localparam logic [7:0] SYNC_SECOND    = 8'h62;
    localparam logic [7:0] CLS_NAV        = 8'h01;
    localparam logic [7:0] CLS_ACK        = 8'h05;
    localparam logic [7:0] CLS_CFG        = 8'h06;
    localparam logic [7:0] ID_NAV_SOL     = 8'h06;
    localparam logic [7:0] ID_NAV_POSLLH  = 8'h02;
    localparam logic [7:0] ID_NAV_TIMEUTC = 8'h21;
    localparam logic [7:0] ID_ACK_ACK     = 8'h01;
    localparam logic [7:0] ID_ACK_NAK     = 8'h00;
    localparam logic [7:0] ID_CFG_PRT     = 8'h00;
    localparam logic [7:0] ID_CFG_RST     = 8'h04;

    localparam logic [2:0] MSG_UNKNOWN     = 3'd0;
    localparam logic [2:0] MSG_NAV_SOL     = 3'd1;
    localparam logic [2:0] MSG_NAV_POSLLH  = 3'd2;
    localparam logic [2:0] MSG_NAV_TIMEUTC = 3'd3;
    localparam logic [2:0] MSG_ACK         = 3'd4;
    localparam logic [2:0] MSG_NAK         = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_CHECKSUM  = 2'd1;
    localparam logic [1:0] ST_TOO_LONG  = 2'd2;
    localparam logic [1:0] ST_UNKNOWN   = 2'd3;

    localparam logic [1:0] SUBJ_CFG_PRT = 2'd0;
    localparam logic [1:0] SUBJ_CFG_RST = 2'd1;
    localparam logic [1:0] SUBJ_OTHER   = 2'd2;

    localparam logic KIND_FIELD  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic        item_kind;
        logic [2:0]  frame_type;
        logic [3:0]  field_index;
        logic [31:0] field_value;
        logic [1:0]  status_code;
        logic [1:0]  ack_subject;
        logic        frame_end;
    } t_result;

    typedef struct packed {
        logic       hit;
        logic [3:0] index;
        logic [1:0] byte_sel;
        logic       last;
    } t_field_slot;

    localparam logic [7:0] SOL_OFF [14] = '{8'd10, 8'd14, 8'd16, 8'd17, 8'd18, 8'd22, 8'd26,
                                           8'd30, 8'd34, 8'd38, 8'd42, 8'd46, 8'd50, 8'd53};
    localparam logic [2:0] SOL_WID [14] = '{3'd4, 3'd2, 3'd1, 3'd1, 3'd4, 3'd4, 3'd4,
                                           3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd2, 3'd1};
    localparam logic [7:0] POS_OFF [7]  = '{8'd6, 8'd10, 8'd14, 8'd18, 8'd22, 8'd26, 8'd30};
    localparam logic [2:0] POS_WID [7]  = '{3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4};
    localparam logic [7:0] UTC_OFF [9]  = '{8'd10, 8'd14, 8'd18, 8'd20, 8'd21, 8'd22, 8'd23,
                                           8'd24, 8'd25};
    localparam logic [2:0] UTC_WID [9]  = '{3'd4, 3'd4, 3'd2, 3'd1, 3'd1, 3'd1, 3'd1,
                                           3'd1, 3'd1};

    function automatic t_field_slot slot_of(input logic [7:0] pos, input logic [7:0] off,
                                            input logic [2:0] wid, input logic [3:0] idx);
        t_field_slot s;
        logic [8:0]  rel;
        rel        = {1'b0, pos} - {1'b0, off};
        s.hit      = (pos >= off) && ({1'b0, pos} < ({1'b0, off} + 9'(wid)));
        s.index    = idx;
        s.byte_sel = rel[1:0];
        s.last     = (rel == (9'(wid) - 9'd1));
        return s;
    endfunction

    function automatic t_field_slot field_lookup(input logic [2:0] frame_type,
                                                 input logic [7:0] pos);
        t_field_slot slot;
        t_field_slot t;
        slot = '0;
        for (int i = 0; i < 14; i++) begin
            t = slot_of(pos, SOL_OFF[i], SOL_WID[i], 4'(i));
            if (frame_type == MSG_NAV_SOL && t.hit) slot = t;
        end
        for (int i = 0; i < 7; i++) begin
            t = slot_of(pos, POS_OFF[i], POS_WID[i], 4'(i));
            if (frame_type == MSG_NAV_POSLLH && t.hit) slot = t;
        end
        for (int i = 0; i < 9; i++) begin
            t = slot_of(pos, UTC_OFF[i], UTC_WID[i], 4'(i));
            if (frame_type == MSG_NAV_TIMEUTC && t.hit) slot = t;
        end
        return slot;
    endfunction

endpackage

@@ sv/ubx_parse_core.sv @@
// ----------------------------------------------------------------------------
// UBX parse core
// Byte state machine: sync hunt, header, Fletcher sum, field extraction
// and end of frame status, one byte per step.
// ----------------------------------------------------------------------------
module ubx_parse_core #(
    parameter int FRAME_BYTES = ubx_pkg::FRAME_BYTES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_rx_byte,
    output logic             o_emit,
    output ubx_pkg::t_result o_result
);
    import ubx_pkg::*;

    localparam logic [3:0] PH_HUNT1   = 4'd0;
    localparam logic [3:0] PH_HUNT2   = 4'd1;
    localparam logic [3:0] PH_CLASS   = 4'd2;
    localparam logic [3:0] PH_ID      = 4'd3;
    localparam logic [3:0] PH_LEN_LO  = 4'd4;
    localparam logic [3:0] PH_LEN_HI  = 4'd5;
    localparam logic [3:0] PH_PAYLOAD = 4'd6;
    localparam logic [3:0] PH_CK_A    = 4'd7;
    localparam logic [3:0] PH_CK_B    = 4'd8;

    logic [3:0]  r_phase, n_phase;
    logic [7:0]  r_pos, n_pos;
    logic [7:0]  r_class, n_class;
    logic [7:0]  r_id, n_id;
    logic [15:0] r_len, n_len;
    logic [7:0]  r_sum_a, n_sum_a;
    logic [7:0]  r_sum_b, n_sum_b;
    logic [31:0] r_acc, n_acc;
    logic [7:0]  r_ack_cls, n_ack_cls;
    logic [7:0]  r_ack_id, n_ack_id;

    logic [2:0]  w_type;
    logic [7:0]  w_sa_add;
    logic [7:0]  w_sb_add;
    logic [15:0] w_len_full;
    logic [1:0]  w_subject;
    logic [31:0] w_acc_new;
    t_field_slot w_slot;

    always_comb begin
        w_type = MSG_UNKNOWN;
        if (r_class == CLS_NAV) begin
            if (r_id == ID_NAV_SOL) w_type = MSG_NAV_SOL;
            else if (r_id == ID_NAV_POSLLH) w_type = MSG_NAV_POSLLH;
            else if (r_id == ID_NAV_TIMEUTC) w_type = MSG_NAV_TIMEUTC;
        end else if (r_class == CLS_ACK) begin
            if (r_id == ID_ACK_ACK) w_type = MSG_ACK;
            else if (r_id == ID_ACK_NAK) w_type = MSG_NAK;
        end
    end

    always_comb begin
        w_subject = SUBJ_OTHER;
        if ((w_type == MSG_ACK || w_type == MSG_NAK) && r_ack_cls == CLS_CFG) begin
            if (r_ack_id == ID_CFG_PRT) w_subject = SUBJ_CFG_PRT;
            else if (r_ack_id == ID_CFG_RST) w_subject = SUBJ_CFG_RST;
        end
    end

    assign w_sa_add   = r_sum_a + i_rx_byte;
    assign w_sb_add   = r_sum_b + w_sa_add;
    assign w_len_full = {i_rx_byte, r_len[7:0]};
    assign w_slot     = field_lookup(w_type, r_pos);
    assign w_acc_new  = (w_slot.byte_sel == 2'd0) ? {24'd0, i_rx_byte}
                      : (r_acc | ({24'd0, i_rx_byte} << {w_slot.byte_sel, 3'b000}));

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_class   = r_class;
        n_id      = r_id;
        n_len     = r_len;
        n_sum_a   = r_sum_a;
        n_sum_b   = r_sum_b;
        n_acc     = r_acc;
        n_ack_cls = r_ack_cls;
        n_ack_id  = r_ack_id;
        o_emit    = 1'b0;
        o_result  = '{item_kind: KIND_STATUS, frame_type: w_type, field_index: 4'd0,
                      field_value: 32'd0, status_code: ST_OK, ack_subject: SUBJ_OTHER,
                      frame_end: 1'b1};
        case (r_phase)
            PH_HUNT1: begin
                if (i_rx_byte == SYNC_FIRST) n_phase = PH_HUNT2;
            end
            PH_HUNT2: begin
                if (i_rx_byte == SYNC_SECOND) begin
                    n_phase   = PH_CLASS;
                    n_pos     = 8'd2;
                    n_class   = '0;
                    n_id      = '0;
                    n_len     = '0;
                    n_sum_a   = '0;
                    n_sum_b   = '0;
                    n_acc     = '0;
                    n_ack_cls = '0;
                    n_ack_id  = '0;
                end else if (i_rx_byte != SYNC_FIRST) begin
                    n_phase = PH_HUNT1;
                end
            end
            PH_CLASS: begin
                n_class = i_rx_byte;
                n_sum_a = w_sa_add;
                n_sum_b = w_sb_add;
                n_pos   = 8'd3;
                n_phase = PH_ID;
            end
            PH_ID: begin
                n_id    = i_rx_byte;
                n_sum_a = w_sa_add;
                n_sum_b = w_sb_add;
                n_pos   = 8'd4;
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_len   = {8'd0, i_rx_byte};
                n_sum_a = w_sa_add;
                n_sum_b = w_sb_add;
                n_pos   = 8'd5;
                n_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_len   = w_len_full;
                n_sum_a = w_sa_add;
                n_sum_b = w_sb_add;
                n_pos   = 8'(HEADER_BYTES);
                if ((17'(w_len_full) + 17'(FRAME_OVERHEAD)) > 17'(FRAME_BYTES)) begin
                    o_emit               = 1'b1;
                    o_result.status_code = ST_TOO_LONG;
                    n_phase              = PH_HUNT1;
                    n_pos                = 8'd0;
                end else if (w_len_full == 16'd0) begin
                    n_phase = PH_CK_A;
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_sum_a = w_sa_add;
                n_sum_b = w_sb_add;
                if (w_type == MSG_ACK || w_type == MSG_NAK) begin
                    if (r_pos == 8'(HEADER_BYTES)) n_ack_cls = i_rx_byte;
                    else if (r_pos == 8'(HEADER_BYTES + 1)) n_ack_id = i_rx_byte;
                end
                if (w_slot.hit) begin
                    n_acc = w_acc_new;
                    if (w_slot.last) begin
                        o_emit   = 1'b1;
                        o_result = '{item_kind: KIND_FIELD, frame_type: w_type,
                                     field_index: w_slot.index, field_value: w_acc_new,
                                     status_code: ST_OK, ack_subject: SUBJ_OTHER,
                                     frame_end: 1'b0};
                    end
                end
                if ((17'(r_pos) + 17'd1) >= (17'(HEADER_BYTES) + 17'(r_len))) begin
                    n_phase = PH_CK_A;
                end
                n_pos = r_pos + 8'd1;
            end
            PH_CK_A: begin
                n_sum_a = r_sum_a ^ i_rx_byte;
                n_pos   = r_pos + 8'd1;
                n_phase = PH_CK_B;
            end
            PH_CK_B: begin
                o_emit               = 1'b1;
                o_result.ack_subject = w_subject;
                if (r_sum_a != 8'd0 || r_sum_b != i_rx_byte) begin
                    o_result.status_code = ST_CHECKSUM;
                end else if (w_type == MSG_UNKNOWN) begin
                    o_result.status_code = ST_UNKNOWN;
                end
                n_phase = PH_HUNT1;
                n_pos   = 8'd0;
            end
            default: begin
                n_phase = PH_HUNT1;
                n_pos   = 8'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT1;
            r_pos     <= '0;
            r_class   <= '0;
            r_id      <= '0;
            r_len     <= '0;
            r_sum_a   <= '0;
            r_sum_b   <= '0;
            r_acc     <= '0;
            r_ack_cls <= '0;
            r_ack_id  <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_class   <= n_class;
            r_id      <= n_id;
            r_len     <= n_len;
            r_sum_a   <= n_sum_a;
            r_sum_b   <= n_sum_b;
            r_acc     <= n_acc;
            r_ack_cls <= n_ack_cls;
            r_ack_id  <= n_ack_id;
        end
    end

endmodule

@@ sv/ubx_frame_parser_top.sv @@
// ----------------------------------------------------------------------------
// UBX frame parser top level
// Parses a receiver byte stream into extracted navigation fields and one
// status transaction per frame.
//
// Input channel: i_valid / o_ready with i_rx_byte, one byte per transaction.
// Output channel: o_valid / i_ready with the result fields. Each byte gives
// zero or one result: a field transaction when the last byte of a known
// field arrives, a status transaction (o_frame_end high) at the second
// checksum byte or right after the length when the frame is too long.
// Throughput: one byte per cycle while no result waits on a low i_ready. A byte
// is held in an input register, runs through the parse logic once the output
// register is free, and its result is registered in the output register.
// Reset empties both registers and returns the parser to the sync hunt.
// When i_ready is low and a result waits, the input register holds one more
// byte; o_ready then drops until the result is taken.
// ----------------------------------------------------------------------------
module ubx_frame_parser_top #(
    parameter int FRAME_BYTES = ubx_pkg::FRAME_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_item_kind,
    output logic [2:0]  o_frame_type,
    output logic [3:0]  o_field_index,
    output logic [31:0] o_field_value,
    output logic [1:0]  o_status_code,
    output logic [1:0]  o_ack_subject,
    output logic        o_frame_end
);
    import ubx_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;

    logic    w_adv;
    logic    w_step;
    logic    w_emit;
    t_result w_result;

    assign w_adv   = !r_out_valid || i_ready;
    assign w_step  = r_in_valid && w_adv;
    assign o_ready = !r_in_valid || w_adv;

    ubx_parse_core #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_rx_byte (r_in_byte),
        .o_emit    (w_emit),
        .o_result  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) r_in_valid <= i_valid;
            if (w_adv) r_out_valid <= w_step && w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) r_in_byte <= i_rx_byte;
        if (w_step && w_emit) r_out <= w_result;
    end

    assign o_valid       = r_out_valid;
    assign o_item_kind   = r_out.item_kind;
    assign o_frame_type  = r_out.frame_type;
    assign o_field_index = r_out.field_index;
    assign o_field_value = r_out.field_value;
    assign o_status_code = r_out.status_code;
    assign o_ack_subject = r_out.ack_subject;
    assign o_frame_end   = r_out.frame_end;

    a_status_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item_kind == KIND_STATUS) == o_frame_end)
        else $error("status transaction and frame end disagree");

    a_field_nav_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item_kind == KIND_FIELD) |->
            (o_frame_type == MSG_NAV_SOL || o_frame_type == MSG_NAV_POSLLH ||
             o_frame_type == MSG_NAV_TIMEUTC))
        else $error("field transaction from a message without fields");

    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_in_valid && r_out_valid && !i_ready))
        else $error("input stalled while a stage is free");

    a_no_result_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");

endmodule
